@@ design/gds_pkg.sv @@
// Shared types, constants and helpers for the grid depth-first search step engine.
`timescale 1ns / 1ps

package gds_pkg;

  // Grid storage geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_W    = 6;
  localparam int DIM_W      = 7;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIST_W  = 12;
  localparam int EPOCH_W = 8;
  localparam int DIR_W   = 3;
  localparam int PAR_W   = 4;
  localparam int KIND_W  = 2;

  localparam logic [DIST_W-1:0]  DIST_MAX    = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [ADDR_W-1:0]  CNT_LAST    = '1;
  localparam logic [DIR_W-1:0]   DIR_FIRST   = '0;
  localparam logic [DIR_W-1:0]   DIR_LAST    = '1;
  localparam logic [PAR_W-1:0]   NO_PARENT   = PAR_W'(8);
  localparam logic [DIM_W-1:0]   DIM_MIN     = DIM_W'(1);
  localparam logic [DIM_W-1:0]   DIM_MAX_W   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]   DIM_MAX_H   = DIM_W'(MAX_HEIGHT);

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_START_X     = 2'd2;
  localparam logic [1:0] REG_START_Y     = 2'd3;

  // Opcodes (any code with bit 1 set is a step)
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;

  // Cell kinds
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  typedef enum logic [2:0] {
    ST_MOVED       = 3'd0,
    ST_BACKTRACKED = 3'd1,
    ST_END_REACHED = 3'd2,
    ST_FINISHED    = 3'd3,
    ST_LOADED      = 3'd4,
    ST_RESTARTED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SRCH_IDLE      = 2'd0,
    SRCH_ACTIVE    = 2'd1,
    SRCH_FOUND     = 2'd2,
    SRCH_EXHAUSTED = 2'd3
  } srch_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WIPE,
    S_RESTART,
    S_HERE,
    S_HERE_CHK,
    S_NB,
    S_NB_CHK,
    S_BACK,
    S_BACK_RD
  } state_t;

  // Per-cell search record; a cell counts as visited when its epoch is current
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [PAR_W-1:0]   parent;
    logic [DIST_W-1:0]  distance;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // Direction order W, S, E, N, NE, SE, SW, NW; x grows east, y grows south
  function automatic logic signed [DIM_W:0] dir_dx(input logic [DIR_W-1:0] d);
    logic signed [DIM_W:0] r;
    case (d)
      3'd0:    r = -8'sd1;
      3'd1:    r = 8'sd0;
      3'd2:    r = 8'sd1;
      3'd3:    r = 8'sd0;
      3'd4:    r = 8'sd1;
      3'd5:    r = 8'sd1;
      3'd6:    r = -8'sd1;
      3'd7:    r = -8'sd1;
      default: r = 8'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DIM_W:0] dir_dy(input logic [DIR_W-1:0] d);
    logic signed [DIM_W:0] r;
    case (d)
      3'd0:    r = 8'sd0;
      3'd1:    r = 8'sd1;
      3'd2:    r = 8'sd0;
      3'd3:    r = -8'sd1;
      3'd4:    r = -8'sd1;
      3'd5:    r = 8'sd1;
      3'd6:    r = 8'sd1;
      3'd7:    r = -8'sd1;
      default: r = 8'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (r < DIM_MIN) r = DIM_MIN;
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

@@ design/gds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/grid_dfs_step_engine_top.sv @@
// Top level of the grid depth-first search step engine.
`timescale 1ns / 1ps
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------------------
//  input   | in_opcode, in_cell_x, in_cell_y, in_cell_kind | taken when start && !busy
//  result  | out_status, out_walker_x/_y/_distance         | out_strobe, one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_wdata                  | written when cfg_we, any cycle
//
// Timing: a load is answered in the next cycle and busy stays low. A restart passes through
// S_RESTART; every 255th restart first sweeps the search-record RAM to retire old epochs. A
// step reads the current cell in S_HERE and S_HERE_CHK, then per direction uses S_NB if the
// neighbour lies off the grid or S_NB and S_NB_CHK if its RAM words must be read, then S_BACK
// and S_BACK_RD to backtrack; the single read port of the grid RAMs and the shared coordinate
// adder set this. Reset: after rst_n rises busy stays high during a clearing pass over both RAMs.
// The receiver cannot stall; each result transaction is shown for exactly one cycle.

module grid_dfs_step_engine_top
  import gds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_opcode,
  input  logic [COORD_W-1:0]  in_cell_x,
  input  logic [COORD_W-1:0]  in_cell_y,
  input  logic [KIND_W-1:0]   in_cell_kind,
  // result channel
  output logic                out_strobe,
  output logic [2:0]          out_status,
  output logic [COORD_W-1:0]  out_walker_x,
  output logic [COORD_W-1:0]  out_walker_y,
  output logic [DIST_W-1:0]   out_walker_distance,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [DIM_W-1:0]    cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  srch_t                srch_r, srch_nxt;
  logic [COORD_W-1:0]   walker_x_r, walker_x_nxt;
  logic [COORD_W-1:0]   walker_y_r, walker_y_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;       // distance recorded for the walker's cell
  logic [PAR_W-1:0]     parent_r, parent_nxt;   // parent direction of the walker's cell
  logic [DIR_W-1:0]     dir_r, dir_nxt;         // direction under test
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;     // current visited-mark epoch
  logic [ADDR_W-1:0]    cnt_r, cnt_nxt;         // sweep address

  logic                 out_strobe_r, out_strobe_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [COORD_W-1:0]   out_x_r, out_x_nxt;
  logic [COORD_W-1:0]   out_y_r, out_y_nxt;
  logic [DIST_W-1:0]    out_dist_r, out_dist_nxt;

  logic [DIM_W-1:0]     grid_width_r, grid_height_r;
  logic [COORD_W-1:0]   start_x_r, start_y_r;

  // ---------------------------------------------------------------------------
  // Grid RAMs: cell kind, and per-cell search record (epoch, parent, distance)
  // ---------------------------------------------------------------------------
  logic                 kind_we;
  logic [ADDR_W-1:0]    kind_waddr;
  logic [KIND_W-1:0]    kind_wdata;
  logic [KIND_W-1:0]    kind_rdata;
  logic                 meta_we;
  logic [ADDR_W-1:0]    meta_waddr;
  meta_t                meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  meta_t                meta_rd;
  logic [ADDR_W-1:0]    rd_addr;

  gds_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (kind_waddr),
    .wdata (kind_wdata),
    .raddr (rd_addr),
    .rdata (kind_rdata)
  );

  gds_ram #(.WIDTH(META_W), .DEPTH(CELLS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_addr),
    .rdata (meta_rdata)
  );

  assign meta_rd = meta_t'(meta_rdata);

  // ---------------------------------------------------------------------------
  // Grid bounds and start cell, saturated to the grid in use
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   grid_w, grid_h, grid_w_m1, grid_h_m1;
  logic [COORD_W-1:0] start_sx, start_sy;

  assign grid_w    = clamp_dim(grid_width_r, DIM_MAX_W);
  assign grid_h    = clamp_dim(grid_height_r, DIM_MAX_H);
  assign grid_w_m1 = grid_w - DIM_MIN;
  assign grid_h_m1 = grid_h - DIM_MIN;
  assign start_sx  = ({1'b0, start_x_r} < grid_w) ? start_x_r : grid_w_m1[COORD_W-1:0];
  assign start_sy  = ({1'b0, start_y_r} < grid_h) ? start_y_r : grid_h_m1[COORD_W-1:0];

  // ---------------------------------------------------------------------------
  // Shared coordinate adder: neighbour in direction dir_r, or parent cell
  // (walker minus the parent's move) while backtracking
  // ---------------------------------------------------------------------------
  logic [DIR_W-1:0]      add_dir;
  logic                  add_neg;
  logic signed [DIM_W:0] off_x, off_y, sum_x, sum_y;
  logic                  in_grid;
  logic [ADDR_W-1:0]     nb_addr;
  logic [ADDR_W-1:0]     here_addr;

  assign add_neg = (state_r == S_BACK);
  assign add_dir = add_neg ? parent_r[DIR_W-1:0] : dir_r;
  assign off_x   = add_neg ? -dir_dx(add_dir) : dir_dx(add_dir);
  assign off_y   = add_neg ? -dir_dy(add_dir) : dir_dy(add_dir);
  assign sum_x   = signed'({2'b00, walker_x_r}) + off_x;
  assign sum_y   = signed'({2'b00, walker_y_r}) + off_y;
  assign in_grid = !sum_x[DIM_W] && (sum_x[DIM_W-1:0] < grid_w) &&
                   !sum_y[DIM_W] && (sum_y[DIM_W-1:0] < grid_h);
  assign nb_addr   = {sum_y[COORD_W-1:0], sum_x[COORD_W-1:0]};
  assign here_addr = {walker_y_r, walker_x_r};

  // ---------------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------------
  logic acc, op_load, op_restart, op_step, cand_free;
  logic [DIST_W-1:0] dist_inc;

  assign busy       = (state_r != S_IDLE);
  assign acc        = start && !busy;
  assign op_load    = (in_opcode == OP_LOAD);
  assign op_restart = (in_opcode == OP_RESTART);
  assign op_step    = !op_load && !op_restart;
  // neighbour candidate is free when not a wall and not stamped with this epoch
  assign cand_free  = (kind_rdata != KIND_WALL) && (meta_rd.epoch != epoch_r);
  assign dist_inc   = (dist_r < DIST_MAX) ? dist_r + DIST_W'(1) : dist_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == CNT_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (op_restart) begin
            state_nxt = (epoch_r == EPOCH_LAST) ? S_WIPE : S_RESTART;
          end else if (op_step && srch_r == SRCH_ACTIVE) begin
            state_nxt = S_HERE;
          end
        end
      end
      S_WIPE: begin
        if (cnt_r == CNT_LAST) state_nxt = S_RESTART;
      end
      S_RESTART: state_nxt = S_IDLE;
      S_HERE:    state_nxt = S_HERE_CHK;
      S_HERE_CHK: begin
        state_nxt = (kind_rdata == KIND_END) ? S_IDLE : S_NB;
      end
      S_NB: begin
        if (in_grid) state_nxt = S_NB_CHK;
        else if (dir_r == DIR_LAST) state_nxt = S_BACK;
      end
      S_NB_CHK: begin
        if (cand_free) state_nxt = S_IDLE;
        else if (dir_r == DIR_LAST) state_nxt = S_BACK;
        else state_nxt = S_NB;
      end
      S_BACK: begin
        state_nxt = (parent_r >= NO_PARENT) ? S_IDLE : S_BACK_RD;
      end
      S_BACK_RD: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath control, RAM ports and result
  // ---------------------------------------------------------------------------
  logic    emit;
  status_t emit_status;

  always_comb begin
    srch_nxt     = srch_r;
    walker_x_nxt = walker_x_r;
    walker_y_nxt = walker_y_r;
    dist_nxt     = dist_r;
    parent_nxt   = parent_r;
    dir_nxt      = dir_r;
    epoch_nxt    = epoch_r;
    cnt_nxt      = cnt_r;
    emit         = 1'b0;
    emit_status  = ST_FINISHED;
    kind_we      = 1'b0;
    kind_waddr   = cnt_r;
    kind_wdata   = KIND_OPEN;
    meta_we      = 1'b0;
    meta_waddr   = cnt_r;
    meta_wdata   = '0;
    rd_addr      = here_addr;

    case (state_r)
      S_CLEAR: begin
        kind_we = 1'b1;
        meta_we = 1'b1;
        cnt_nxt = cnt_r + ADDR_W'(1);
      end
      S_IDLE: begin
        if (acc) begin
          if (op_load) begin
            kind_we     = 1'b1;
            kind_waddr  = {in_cell_y, in_cell_x};
            kind_wdata  = in_cell_kind;
            emit        = 1'b1;
            emit_status = ST_LOADED;
          end else if (op_restart) begin
            if (epoch_r != EPOCH_LAST) epoch_nxt = epoch_r + EPOCH_W'(1);
          end else if (srch_r != SRCH_ACTIVE) begin
            emit        = 1'b1;
            emit_status = ST_FINISHED;
          end
        end
      end
      S_WIPE: begin
        // epochs ran out: retire every old visited mark
        meta_we = 1'b1;
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == CNT_LAST) epoch_nxt = EPOCH_FIRST;
      end
      S_RESTART: begin
        meta_we             = 1'b1;
        meta_waddr          = {start_sy, start_sx};
        meta_wdata.epoch    = epoch_r;
        meta_wdata.parent   = NO_PARENT;
        meta_wdata.distance = '0;
        walker_x_nxt        = start_sx;
        walker_y_nxt        = start_sy;
        dist_nxt            = '0;
        srch_nxt            = SRCH_ACTIVE;
        emit                = 1'b1;
        emit_status         = ST_RESTARTED;
      end
      S_HERE: begin
        rd_addr = here_addr;
      end
      S_HERE_CHK: begin
        if (kind_rdata == KIND_END) begin
          srch_nxt    = SRCH_FOUND;
          emit        = 1'b1;
          emit_status = ST_END_REACHED;
        end else begin
          parent_nxt = meta_rd.parent;
          dir_nxt    = DIR_FIRST;
        end
      end
      S_NB: begin
        rd_addr = nb_addr;
        if (!in_grid && dir_r != DIR_LAST) dir_nxt = dir_r + DIR_W'(1);
      end
      S_NB_CHK: begin
        rd_addr = nb_addr;
        if (cand_free) begin
          meta_we             = 1'b1;
          meta_waddr          = nb_addr;
          meta_wdata.epoch    = epoch_r;
          meta_wdata.parent   = {1'b0, dir_r};
          meta_wdata.distance = dist_inc;
          walker_x_nxt        = sum_x[COORD_W-1:0];
          walker_y_nxt        = sum_y[COORD_W-1:0];
          dist_nxt            = dist_inc;
          emit                = 1'b1;
          emit_status         = ST_MOVED;
        end else if (dir_r != DIR_LAST) begin
          dir_nxt = dir_r + DIR_W'(1);
        end
      end
      S_BACK: begin
        if (parent_r >= NO_PARENT) begin
          srch_nxt    = SRCH_EXHAUSTED;
          emit        = 1'b1;
          emit_status = ST_FINISHED;
        end else begin
          rd_addr      = nb_addr;
          walker_x_nxt = sum_x[COORD_W-1:0];
          walker_y_nxt = sum_y[COORD_W-1:0];
        end
      end
      S_BACK_RD: begin
        dist_nxt    = meta_rd.distance;
        emit        = 1'b1;
        emit_status = ST_BACKTRACKED;
      end
      default: ;
    endcase

    out_strobe_nxt = emit;
    out_status_nxt = emit ? emit_status : out_status_r;
    out_x_nxt      = emit ? walker_x_nxt : out_x_r;
    out_y_nxt      = emit ? walker_y_nxt : out_y_r;
    if (!emit) out_dist_nxt = out_dist_r;
    else if (srch_nxt == SRCH_IDLE) out_dist_nxt = '0;
    else out_dist_nxt = dist_nxt;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      srch_r        <= SRCH_IDLE;
      walker_x_r    <= '0;
      walker_y_r    <= '0;
      dist_r        <= '0;
      epoch_r       <= EPOCH_FIRST;
      cnt_r         <= '0;
      out_strobe_r  <= 1'b0;
      grid_width_r  <= DIM_MAX_W;
      grid_height_r <= DIM_MAX_H;
      start_x_r     <= '0;
      start_y_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      srch_r       <= srch_nxt;
      walker_x_r   <= walker_x_nxt;
      walker_y_r   <= walker_y_nxt;
      dist_r       <= dist_nxt;
      epoch_r      <= epoch_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
          REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
          REG_START_X:     start_x_r     <= cfg_wdata[COORD_W-1:0];
          REG_START_Y:     start_y_r     <= cfg_wdata[COORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    parent_r     <= parent_nxt;
    dir_r        <= dir_nxt;
    out_status_r <= out_status_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_walker_x        = out_x_r;
  assign out_walker_y        = out_y_r;
  assign out_walker_distance = out_dist_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_load_answers_next: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op_load) |=> (out_strobe_r && out_status_r == ST_LOADED))
    else $error("load transaction not answered in the next cycle");

  a_dead_step_holds_walker: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op_step && srch_r != SRCH_ACTIVE) |=>
      (out_strobe_r && out_status_r == ST_FINISHED &&
       out_x_r == $past(walker_x_r) && out_y_r == $past(walker_y_r)))
    else $error("step outside an active search changed the walker");

  a_sweep_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR || state_r == S_WIPE) |-> (busy && !out_strobe_r))
    else $error("result or acceptance during a RAM sweep");

  a_move_inside_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_status_r == ST_MOVED) |->
      ({1'b0, out_x_r} < grid_w && {1'b0, out_y_r} < grid_h && srch_r == SRCH_ACTIVE))
    else $error("walker moved outside the grid in use");

  a_move_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NB_CHK && cand_free) |=>
      (out_dist_r == $past(dist_inc) && dist_r == out_dist_r))
    else $error("moved-to distance is not the walker distance plus one");

endmodule
